// File: hdl/vwt_pkg.sv
// ----------------------------------------------------------------------------
// Vertex weld package
// Shared sizes, command codes and the front-to-back queue entry type.
// ----------------------------------------------------------------------------
package vwt_pkg;

	localparam int MaxNodes = 1024;
	localparam int IdxW     = $clog2(MaxNodes);
	localparam int CntW     = IdxW + 1;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_REMAP = 2'd2;

	localparam logic [1:0] CFG_TOL   = 2'd0;
	localparam logic [1:0] CFG_CUT_X = 2'd1;
	localparam logic [1:0] CFG_CUT_Y = 2'd2;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_LOAD,
		OP_REMAP,
		OP_BAD
	} op_t;

	// Classified item as handed from the front to the back.
	typedef struct packed {
		op_t         op;
		logic        cand;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [9:0]  vnode;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_CMP,
		ST_REP,
		ST_DONE
	} back_state_t;

endpackage

// File: hdl/vwt_front.sv
// ----------------------------------------------------------------------------
// Vertex weld front end
// Accepts items, finds the cut residual of x and y one quotient bit a cycle,
// and pushes classified jobs into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module vwt_front import vwt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [9:0]  vertex_node,
	input  logic [30:0] tolerance,
	input  logic [30:0] cut_x,
	input  logic [30:0] cut_y,
	output logic        job_valid,
	input  logic        job_ready,
	output job_t        job
);

	job_t        cur_q;
	logic        busy_q;
	logic [5:0]  step_q;
	logic [31:0] ux_q, uy_q;  // magnitude being divided
	logic [31:0] rx_q, ry_q;  // partial remainder

	job_t        fifo_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        pop;
	logic        done;
	logic [31:0] rx_n, ry_n;
	logic [32:0] tx, ty;
	job_t        push_job;

	assign in_ready  = !busy_q;
	assign done      = busy_q && step_q == 6'd32;
	assign push      = done && cnt_q != 2'd2;
	assign pop       = job_valid && job_ready;
	assign job_valid = cnt_q != 2'd0;
	assign job       = fifo_q[rp_q];

	// Restoring division step of the magnitude by the cut.
	assign tx = {rx_q, ux_q[31]} - {2'b0, cut_x};
	assign ty = {ry_q, uy_q[31]} - {2'b0, cut_y};
	assign rx_n = tx[32] ? {rx_q[30:0], ux_q[31]} : tx[31:0];
	assign ry_n = ty[32] ? {ry_q[30:0], uy_q[31]} : ty[31:0];

	// Residual test from the remainder of |p|; for negative p the floor
	// remainder is c - r, which gives the same nearest distance.
	function automatic logic near(input logic [31:0] r, input logic [30:0] c,
		input logic [30:0] t);
		logic [31:0] a;
		logic [31:0] b;
		begin
			a = r;
			b = {1'b0, c} - r;
			if (b < a) a = b;
			near = (c == 31'd0) || (a <= {1'b0, t});
		end
	endfunction

	always_comb begin
		push_job      = cur_q;
		push_job.cand = near(rx_q, cut_x, tolerance) || near(ry_q, cut_y, tolerance);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q && !done) begin
				step_q <= step_q + 6'd1;
			end else if (push) begin
				busy_q <= 1'b0;
			end
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			case (command)
				CMD_CLEAR: cur_q.op <= OP_CLEAR;
				CMD_LOAD:  cur_q.op <= OP_LOAD;
				CMD_REMAP: cur_q.op <= OP_REMAP;
				default:   cur_q.op <= OP_BAD;
			endcase
			cur_q.cand  <= 1'b0;
			cur_q.x     <= pos_x;
			cur_q.y     <= pos_y;
			cur_q.z     <= pos_z;
			cur_q.vnode <= vertex_node;
			ux_q <= pos_x[31] ? 32'd0 - pos_x : pos_x;
			uy_q <= pos_y[31] ? 32'd0 - pos_y : pos_y;
			rx_q <= '0;
			ry_q <= '0;
		end else if (busy_q && !done) begin
			rx_q <= (cut_x == 31'd0) ? '0 : rx_n;
			ry_q <= (cut_y == 31'd0) ? '0 : ry_n;
			ux_q <= {ux_q[30:0], 1'b0};
			uy_q <= {uy_q[30:0], 1'b0};
		end
		if (push) begin
			fifo_q[wp_q] <= push_job;
		end
	end

endmodule

// File: hdl/vwt_back.sv
// ----------------------------------------------------------------------------
// Vertex weld back end
// Holds the node and candidate memories, scans earlier candidates for the
// last matching one and registers one result for the output.
// ----------------------------------------------------------------------------
module vwt_back import vwt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	output logic             job_ready,
	input  job_t             job,
	input  logic [30:0]      tolerance,
	output logic             res_valid,
	input  logic             res_ready,
	output logic [IdxW-1:0]  res_index,
	output logic             res_merged,
	output logic             res_error
);

	logic [31:0]   mem_x [MaxNodes];
	logic [31:0]   mem_y [MaxNodes];
	logic [31:0]   mem_z [MaxNodes];
	logic [IdxW:0] mem_rep [MaxNodes];
	logic [IdxW-1:0] mem_cand [MaxNodes];

	back_state_t   state_q, state_d;
	job_t          job_q;
	logic [CntW-1:0] ncount_q, ccount_q, k_q;
	logic [IdxW:0] rep_q;
	logic [IdxW-1:0] p_q;
	logic [31:0]   px_q, py_q, pz_q;
	logic [IdxW:0] prep_q;
	logic [IdxW-1:0] cand_rd_q;
	logic [IdxW:0] rep_rd_q;
	logic [32:0]   dx_s1, dy_s1, dz_s1;
	logic          far_s1;
	logic [63:0]   sq_s2;
	logic [1:0]    sub_q;
	logic [65:0]   acc_q;
	logic [63:0]   tsq_q;
	logic          out_full_q;

	logic signed [32:0] ddx, ddy, ddz;
	logic [32:0] adx, ady, adz;
	logic [32:0] dsel;

	assign ddx = $signed({px_q[31], px_q}) - $signed({job_q.x[31], job_q.x});
	assign ddy = $signed({py_q[31], py_q}) - $signed({job_q.y[31], job_q.y});
	assign ddz = $signed({pz_q[31], pz_q}) - $signed({job_q.z[31], job_q.z});
	assign adx = ddx[32] ? 33'd0 - ddx : ddx;
	assign ady = ddy[32] ? 33'd0 - ddy : ddy;
	assign adz = ddz[32] ? 33'd0 - ddz : ddz;

	always_comb begin
		case (sub_q)
			2'd0:    dsel = dx_s1;
			2'd1:    dsel = dy_s1;
			default: dsel = dz_s1;
		endcase
	end

	assign job_ready = state_q == ST_IDLE && !out_full_q;
	assign res_valid = out_full_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (job_valid && job_ready) begin
				if (job.op == OP_LOAD && ncount_q < CntW'(MaxNodes) && job.cand)
					state_d = ST_SCAN;
				else
					state_d = ST_DONE;
			end
			ST_SCAN: state_d = (k_q == ccount_q) ? ST_DONE : ST_WAIT;
			ST_WAIT: state_d = ST_REP;
			ST_REP:  state_d = ST_CMP;
			ST_CMP:  if (sub_q == 2'd3) state_d = ST_SCAN;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ncount_q   <= '0;
			ccount_q   <= '0;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_valid && res_ready) out_full_q <= 1'b0;
			if (state_q == ST_DONE) begin
				out_full_q <= 1'b1;
				case (job_q.op)
					OP_CLEAR: begin
						ncount_q <= '0;
						ccount_q <= '0;
					end
					OP_LOAD: if (ncount_q < CntW'(MaxNodes)) begin
						ncount_q <= ncount_q + 1'b1;
						if (job_q.cand) ccount_q <= ccount_q + 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		cand_rd_q <= mem_cand[k_q[IdxW-1:0]];
		tsq_q     <= {1'b0, tolerance} * {1'b0, tolerance};
		case (state_q)
			ST_IDLE: begin
				job_q    <= job;
				k_q      <= '0;
				rep_q    <= '1;
				rep_rd_q <= mem_rep[job.vnode];
				if (job_valid && job_ready && job.op == OP_LOAD &&
					ncount_q < CntW'(MaxNodes)) begin
					mem_x[ncount_q[IdxW-1:0]] <= job.x;
					mem_y[ncount_q[IdxW-1:0]] <= job.y;
					mem_z[ncount_q[IdxW-1:0]] <= job.z;
				end
			end
			ST_WAIT: begin
				p_q    <= cand_rd_q;
				px_q   <= mem_x[cand_rd_q];
				py_q   <= mem_y[cand_rd_q];
				pz_q   <= mem_z[cand_rd_q];
				prep_q <= mem_rep[cand_rd_q];
			end
			ST_REP: begin
				// Axis distances are registered ahead of the shared multiplier.
				dx_s1  <= adx;
				dy_s1  <= ady;
				dz_s1  <= adz;
				far_s1 <= adx >= {2'b0, tolerance} || ady >= {2'b0, tolerance} ||
					adz >= {2'b0, tolerance};
				sub_q  <= '0;
				acc_q  <= '0;
			end
			ST_CMP: begin
				sq_s2 <= dsel[31:0] * dsel[31:0];
				sub_q <= sub_q + 2'd1;
				if (sub_q == 2'd3) begin
					if (!far_s1 && acc_q + 66'(sq_s2) < {2'b0, tsq_q})
						rep_q <= prep_q[IdxW] ? {1'b0, p_q} : prep_q;
					k_q <= k_q + 1'b1;
				end else if (sub_q != 2'd0) begin
					acc_q <= acc_q + 66'(sq_s2);
				end
			end
			ST_DONE: begin
				case (job_q.op)
					OP_LOAD: if (ncount_q < CntW'(MaxNodes)) begin
						mem_rep[ncount_q[IdxW-1:0]] <= rep_q;
						if (job_q.cand && ccount_q < CntW'(MaxNodes))
							mem_cand[ccount_q[IdxW-1:0]] <= ncount_q[IdxW-1:0];
						res_index  <= rep_q[IdxW] ? ncount_q[IdxW-1:0] : rep_q[IdxW-1:0];
						res_merged <= !rep_q[IdxW];
						res_error  <= 1'b0;
					end else begin
						res_index  <= '0;
						res_merged <= 1'b0;
						res_error  <= 1'b1;
					end
					OP_REMAP: if ({1'b0, job_q.vnode} >= ncount_q) begin
						res_index  <= '0;
						res_merged <= 1'b0;
						res_error  <= 1'b1;
					end else if (!rep_rd_q[IdxW]) begin
						res_index  <= rep_rd_q[IdxW-1:0];
						res_merged <= 1'b1;
						res_error  <= 1'b0;
					end else begin
						res_index  <= job_q.vnode;
						res_merged <= 1'b0;
						res_error  <= 1'b0;
					end
					OP_BAD: begin
						res_index  <= '0;
						res_merged <= 1'b0;
						res_error  <= 1'b1;
					end
					default: begin
						res_index  <= '0;
						res_merged <= 1'b0;
						res_error  <= 1'b0;
					end
				endcase
			end
			default: ;
		endcase
	end

endmodule

// File: hdl/vertex_weld_tolerance_core.sv
// ----------------------------------------------------------------------------
// Vertex weld tolerance core
// Welds mesh nodes closer than a tolerance, Q16.16 fixed point.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  s_axis  | in        | command, pos_x, pos_y, pos_z, vertex_node
//  m_axis  | out       | node_index, merged, error
//  cfg     | in        | tolerance, cut_x, cut_y
// The front end finds its remainder bit-serially and takes no new item until
// the last one is queued. A load that is a candidate scans every earlier
// candidate in the back end (memory read latency plus a shared multiplier over
// three axes). Other items skip the scan. No clearing pass after reset.
// A two-entry queue parts front and back; a held result stalls the back end,
// and the front keeps accepting until that queue is full and it holds one more item.
module vertex_weld_tolerance_core import vwt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// command[1:0], pos_x[33:2], pos_y[65:34], pos_z[97:66], vertex_node[107:98]
	input  logic [111:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// node_index[9:0], merged[10], error[11]
	output logic [15:0]  m_axis_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [30:0]  cfg_data
);

	logic [30:0] tol_q, cutx_q, cuty_q;
	logic        job_valid, job_ready;
	job_t        job;
	logic [9:0]  idx;
	logic        mrg, err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q  <= '0;
			cutx_q <= '0;
			cuty_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TOL:   tol_q  <= cfg_data;
				CFG_CUT_X: cutx_q <= cfg_data;
				CFG_CUT_Y: cuty_q <= cfg_data;
				default: ;
			endcase
		end
	end

	vwt_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.command(s_axis_tdata[1:0]), .pos_x(s_axis_tdata[33:2]),
		.pos_y(s_axis_tdata[65:34]), .pos_z(s_axis_tdata[97:66]),
		.vertex_node(s_axis_tdata[107:98]),
		.tolerance(tol_q), .cut_x(cutx_q), .cut_y(cuty_q),
		.job_valid, .job_ready, .job
	);

	vwt_back u_back (
		.clk, .arst_n, .job_valid, .job_ready, .job, .tolerance(tol_q),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
		.res_index(idx), .res_merged(mrg), .res_error(err)
	);

	assign m_axis_tdata = {4'd0, err, mrg, idx};

endmodule
